// File: rtl/ipu_pkg.sv
// Shared types, constants and register codes for the integer pixel upscaler.
// Used by every module under rtl/ except ipu_checker; depends on nothing else.
`default_nettype none

package ipu_pkg;

    // Fixed field widths of the ports
    localparam int PIX_W   = 32;
    localparam int IDX_W   = 22;
    localparam int COORD_W = 12;
    localparam int CFG_W   = 12;
    localparam int REGI_W  = 3;

    // Default build parameters
    localparam int DEF_SRC_WIDTH       = 640;
    localparam int DEF_SRC_HEIGHT      = 400;
    localparam int DEF_MAX_SCALE       = 4;
    localparam int DEF_MAX_SCREEN_SIDE = 2048;
    localparam int DEF_QUEUE_DEPTH     = 4;

    // Register reset values
    localparam logic [2:0]        RST_SCALE  = 3'd2;
    localparam logic [CFG_W-1:0]  RST_WIDTH  = 12'd1024;
    localparam logic [CFG_W-1:0]  RST_HEIGHT = 12'd768;

    // Configuration register indexes
    typedef enum logic [REGI_W-1:0] {
        REG_SCALE         = 3'd0,
        REG_OFFSET_X      = 3'd1,
        REG_OFFSET_Y      = 3'd2,
        REG_SCREEN_WIDTH  = 3'd3,
        REG_SCREEN_HEIGHT = 3'd4
    } ipu_reg_e;

    // Raw register contents as written
    typedef struct packed {
        logic [2:0]              scale;
        logic signed [CFG_W-1:0] offset_x;
        logic signed [CFG_W-1:0] offset_y;
        logic [CFG_W-1:0]        screen_width;
        logic [CFG_W-1:0]        screen_height;
    } ipu_cfg_t;

    // One queued block job: clipped window of one source pixel
    typedef struct packed {
        logic [PIX_W-1:0]   pixel;
        logic [COORD_W-1:0] x_first;
        logic [COORD_W-1:0] x_last;
        logic [COORD_W-1:0] y_first;
        logic [COORD_W-1:0] y_last;
        logic [COORD_W-1:0] stride;
        logic [IDX_W-1:0]   row_base;
    } ipu_job_t;

endpackage

`default_nettype wire

// File: rtl/ipu_front.sv
// Front end: accepts source pixels, tracks the source position, clips the
// scaled block against the screen and hands non-empty jobs on. Uses ipu_pkg.
`default_nettype none

module ipu_front
    import ipu_pkg::*;
#(
    parameter int SRC_WIDTH       = DEF_SRC_WIDTH,
    parameter int SRC_HEIGHT      = DEF_SRC_HEIGHT,
    parameter int MAX_SCALE       = DEF_MAX_SCALE,
    parameter int MAX_SCREEN_SIDE = DEF_MAX_SCREEN_SIDE
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ipu_cfg_t         cfg,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [PIX_W-1:0] s_tdata,
    output logic                  job_valid,
    input  wire logic             job_ready,
    output ipu_job_t              job_data
);

    localparam int CW      = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
    localparam int RW      = (SRC_HEIGHT > 1) ? $clog2(SRC_HEIGHT) : 1;
    localparam int SCW     = $clog2(MAX_SCALE + 1);
    localparam int SRC_MAX = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
    localparam int DW      = $clog2(SRC_MAX * MAX_SCALE + 4096) + 1;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic           a_valid_reg, a_valid_next;
    ipu_job_t       a_job_reg, a_job_next;

    logic [SCW-1:0]     s_eff;
    logic [COORD_W-1:0] w_eff, h_eff;
    logic [CW+SCW-1:0]  prod_x;
    logic [RW+SCW-1:0]  prod_y;
    logic signed [DW-1:0] bx, bx_end, by, by_end, w_s, h_s;
    logic signed [DW-1:0] x0, x1, y0, y1;
    logic               hit_x, hit_y, accept;
    logic [2*COORD_W-1:0] base_prod;

    // Effective scale and screen sides
    always_comb begin
        if (cfg.scale == 3'd0) begin
            s_eff = SCW'(1);
        end else if (int'(cfg.scale) > MAX_SCALE) begin
            s_eff = SCW'(MAX_SCALE);
        end else begin
            s_eff = SCW'(cfg.scale);
        end
        w_eff = (int'(cfg.screen_width) > MAX_SCREEN_SIDE) ?
                COORD_W'(MAX_SCREEN_SIDE) : cfg.screen_width;
        h_eff = (int'(cfg.screen_height) > MAX_SCREEN_SIDE) ?
                COORD_W'(MAX_SCREEN_SIDE) : cfg.screen_height;
    end

    // Block placement and clip window; a zero screen side keeps nothing
    always_comb begin
        prod_x = (CW+SCW)'(col_reg) * (CW+SCW)'(s_eff);
        prod_y = (RW+SCW)'(row_reg) * (RW+SCW)'(s_eff);
        bx     = $signed(DW'(prod_x)) + DW'(cfg.offset_x);
        by     = $signed(DW'(prod_y)) + DW'(cfg.offset_y);
        bx_end = bx + $signed(DW'(s_eff));
        by_end = by + $signed(DW'(s_eff));
        w_s    = $signed(DW'(w_eff));
        h_s    = $signed(DW'(h_eff));
        hit_x  = (bx_end > 0) && (bx < w_s) && (w_s > 0);
        hit_y  = (by_end > 0) && (by < h_s) && (h_s > 0);
        x0     = (bx < 0) ? '0 : bx;
        y0     = (by < 0) ? '0 : by;
        x1     = (bx_end > w_s) ? w_s : bx_end;
        y1     = (by_end > h_s) ? h_s : by_end;
    end

    assign s_tready = !a_valid_reg || job_ready;
    assign accept   = s_tvalid && s_tready;

    // Source position counters and job register
    always_comb begin
        col_next     = col_reg;
        row_next     = row_reg;
        a_valid_next = a_valid_reg;
        a_job_next   = a_job_reg;
        if (accept) begin
            if (col_reg == CW'(SRC_WIDTH - 1)) begin
                col_next = '0;
                row_next = (row_reg == RW'(SRC_HEIGHT - 1)) ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
            // fully clipped pixels are dropped here
            a_valid_next       = hit_x && hit_y;
            a_job_next.pixel   = s_tdata;
            a_job_next.x_first = COORD_W'(x0);
            a_job_next.x_last  = COORD_W'(x1 - DW'(1));
            a_job_next.y_first = COORD_W'(y0);
            a_job_next.y_last  = COORD_W'(y1 - DW'(1));
            a_job_next.stride  = w_eff;
            a_job_next.row_base = '0;
        end else if (job_ready) begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            a_valid_reg <= a_valid_next;
        end
        a_job_reg <= a_job_next;
    end

    // First row offset into the framebuffer
    always_comb begin
        base_prod          = a_job_reg.y_first * a_job_reg.stride;
        job_data           = a_job_reg;
        job_data.row_base  = base_prod[IDX_W-1:0];
    end

    assign job_valid = a_valid_reg;

endmodule

`default_nettype wire

// File: rtl/ipu_queue.sv
// Short job queue between the front end and the write walker.
// Register-based ring buffer; uses ipu_pkg for the job type.
`default_nettype none

module ipu_queue
    import ipu_pkg::*;
#(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire ipu_job_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output ipu_job_t      out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    ipu_job_t      mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          push, pop;

    assign in_ready  = (count_reg != NW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ipu_back.sv
// Write walker: steps through one job's clipped window, one framebuffer write
// per cycle unless stalled, into a registered output stage. Uses ipu_pkg.
`default_nettype none

module ipu_back
    import ipu_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             job_valid,
    output logic                  job_ready,
    input  wire ipu_job_t         job_data,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [IDX_W-1:0]      m_index,
    output logic [PIX_W-1:0]      m_pixel,
    output logic                  m_tlast
);

    logic               busy_reg, busy_next;
    ipu_job_t           job_reg, job_next;
    logic [COORD_W-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic [IDX_W-1:0]   base_reg, base_next;
    logic               ov_reg, ov_next, ol_reg, ol_next;
    logic [IDX_W-1:0]   oi_reg, oi_next;
    logic [PIX_W-1:0]   op_reg, op_next;
    logic               step, end_x, end_y, finish;

    assign step      = busy_reg && (!ov_reg || m_tready);
    assign end_x     = (cx_reg == job_reg.x_last);
    assign end_y     = (cy_reg == job_reg.y_last);
    assign finish    = step && end_x && end_y;
    assign job_ready = !busy_reg || finish;

    // Window walk: rows outer, columns inner
    always_comb begin
        busy_next = busy_reg;
        job_next  = job_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        base_next = base_reg;
        ov_next   = ov_reg;
        oi_next   = oi_reg;
        op_next   = op_reg;
        ol_next   = ol_reg;

        if (step) begin
            ov_next = 1'b1;
            oi_next = base_reg + IDX_W'(cx_reg);
            op_next = job_reg.pixel;
            ol_next = end_x && end_y;
            if (end_x) begin
                cx_next   = job_reg.x_first;
                cy_next   = cy_reg + COORD_W'(1);
                base_next = base_reg + IDX_W'(job_reg.stride);
            end else begin
                cx_next = cx_reg + COORD_W'(1);
            end
        end else if (m_tready) begin
            ov_next = 1'b0;
        end

        // load next job, possibly in the cycle the current one ends
        if (job_valid && job_ready) begin
            busy_next = 1'b1;
            job_next  = job_data;
            cx_next   = job_data.x_first;
            cy_next   = job_data.y_first;
            base_next = job_data.row_base;
        end else if (finish) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
        job_reg  <= job_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        base_reg <= base_next;
        oi_reg   <= oi_next;
        op_reg   <= op_next;
        ol_reg   <= ol_next;
    end

    assign m_tvalid = ov_reg;
    assign m_index  = oi_reg;
    assign m_pixel  = op_reg;
    assign m_tlast  = ol_reg;

endmodule

`default_nettype wire

// File: rtl/integer_pixel_upscale_clip_writer.sv
// Integer nearest-neighbor upscaler, framebuffer write side.
// Pixels enter in raster order on s_*; every source pixel becomes a clipped
// scale-by-scale block of writes on m_*, rows outer and columns inner, with
// tlast on the final write of the pixel. A pixel that is clipped away gives
// no writes. The front end takes one pixel per cycle while its queue has
// room; the write walker emits one write per cycle unless m_tready stalls
// it, so an unclipped pixel gives scale*scale writes (4 at the reset scale of
// 2) through its single output stage. A taken pixel passes the front-end job
// register, the queue and the walker's job register before its first write.
// The user must write configuration on cfg_* only while the block is idle;
// the block does not enforce it. Depends on ipu_pkg, ipu_front, ipu_queue, ipu_back.
`default_nettype none

module integer_pixel_upscale_clip_writer
    import ipu_pkg::*;
#(
    parameter int SRC_WIDTH       = DEF_SRC_WIDTH,
    parameter int SRC_HEIGHT      = DEF_SRC_HEIGHT,
    parameter int MAX_SCALE       = DEF_MAX_SCALE,
    parameter int MAX_SCREEN_SIDE = DEF_MAX_SCREEN_SIDE,
    parameter int QUEUE_DEPTH     = DEF_QUEUE_DEPTH
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [REGI_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [31:0]       s_tdata,   // [31:0] pixel_value
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [55:0]            m_tdata,   // [21:0] fb_index, [53:22] fb_pixel, zero
    output logic                   m_tlast    // last_copy
);

    ipu_cfg_t cfg_reg, cfg_next;
    logic     fj_valid, fj_ready, bj_valid, bj_ready;
    ipu_job_t fj_data, bj_data;
    logic [IDX_W-1:0] m_index;
    logic [PIX_W-1:0] m_pixel;

    // Register file write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (ipu_reg_e'(cfg_index))
                REG_SCALE:         cfg_next.scale         = cfg_data[2:0];
                REG_OFFSET_X:      cfg_next.offset_x      = $signed(cfg_data);
                REG_OFFSET_Y:      cfg_next.offset_y      = $signed(cfg_data);
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data;
                REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scale         <= RST_SCALE;
            cfg_reg.offset_x      <= '0;
            cfg_reg.offset_y      <= '0;
            cfg_reg.screen_width  <= RST_WIDTH;
            cfg_reg.screen_height <= RST_HEIGHT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ipu_front #(
        .SRC_WIDTH      (SRC_WIDTH),
        .SRC_HEIGHT     (SRC_HEIGHT),
        .MAX_SCALE      (MAX_SCALE),
        .MAX_SCREEN_SIDE(MAX_SCREEN_SIDE)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .job_valid(fj_valid),
        .job_ready(fj_ready),
        .job_data (fj_data)
    );

    ipu_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (fj_valid),
        .in_ready (fj_ready),
        .in_data  (fj_data),
        .out_valid(bj_valid),
        .out_ready(bj_ready),
        .out_data (bj_data)
    );

    ipu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job_valid(bj_valid),
        .job_ready(bj_ready),
        .job_data (bj_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_index  (m_index),
        .m_pixel  (m_pixel),
        .m_tlast  (m_tlast)
    );

    assign m_tdata = {2'b00, m_pixel, m_index};

endmodule

`default_nettype wire

// File: rtl/ipu_checker.sv
// Port-level assertions for the upscaler write side, bound to the top level.
// Sees only the top-level ports; no package needed.
`default_nettype none

module ipu_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic        m_tlast
);

    // A stalled write holds its item
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled write item changed");

    // Reset empties the output stage
    a_rst_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("write valid after reset");

    // Reset leaves the front end ready for a pixel
    a_rst_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready after reset");

    // No write can appear the cycle after reset releases without a pixel
    a_no_early: assert property (@(posedge aclk)
        !aresetn ##1 aresetn |=> !m_tvalid)
        else $error("write before any pixel could reach the output");

endmodule

bind integer_pixel_upscale_clip_writer ipu_checker u_ipu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);

`default_nettype wire
